// ----- hdl/uart_boot_image_loader_defines.svh -----
// Assertion macros for the boot-image loader.
// Included by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef UART_BOOT_IMAGE_LOADER_DEFINES_SVH
`define UART_BOOT_IMAGE_LOADER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define UBL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ubl: same-cycle check failed");
// Next-cycle implication.
`define UBL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ubl: next-cycle check failed");
`else
`define UBL_ASSERT_IMP(label, ante, cons)
`define UBL_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- hdl/ubl_pkg.sv -----
// Shared types and constants for the boot-image loader.
// No dependencies; used by ubl_fsm, ubl_result_fifo and the top level.
`timescale 1ns / 1ps

package ubl_pkg;

    localparam logic [7:0] B_SOH  = 8'h01;
    localparam logic [7:0] B_STX  = 8'h02;
    localparam logic [7:0] B_ACK  = 8'h06;
    localparam logic [7:0] B_NACK = 8'h15;
    localparam logic [7:0] XOR_INIT = 8'h00;
    localparam logic [7:0] LIMIT_RESET = 8'd10;

    localparam logic [1:0] K_START = 2'd0;
    localparam logic [1:0] K_RX    = 2'd1;
    localparam logic [1:0] K_TXDONE = 2'd2;
    localparam logic [1:0] K_FW    = 2'd3;

    localparam logic [1:0] C_SUCCESS  = 2'd0;
    localparam logic [1:0] C_REFUSED  = 2'd1;
    localparam logic [1:0] C_EXHAUST  = 2'd2;
    localparam logic [1:0] C_MISMATCH = 2'd3;

    localparam logic [0:0] REG_IMAGE_LENGTH  = 1'b0;
    localparam logic [0:0] REG_ATTEMPT_LIMIT = 1'b1;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_W4_STX   = 4'd1;
    localparam logic [3:0] PH_W4_SENT  = 4'd2;
    localparam logic [3:0] PH_W4_ACK   = 4'd3;
    localparam logic [3:0] PH_STREAM   = 4'd4;
    localparam logic [3:0] PH_W4_CRC   = 4'd5;
    localparam logic [3:0] PH_W4_FINAL = 4'd6;
    localparam logic [3:0] PH_DONE     = 4'd7;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       last_of_run;
        logic       firmware_wanted;
        logic       finished;
        logic [1:0] fail_cause;
        logic       close_link;
    } t_result;

    // Up to three results from one request, slot 0 first.
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_burst;

endpackage

// ----- hdl/uart_boot_image_loader.sv -----
// Boot-image loader over a UART byte link: host side of the download handshake.
// Channels: request in (i_in_valid / o_in_stall, fields i_kind, i_data_byte);
//   results out (o_out_valid / i_out_stall, one result per transfer);
//   register writes (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data).
// Register 0 is image_length (read live), register 1 is attempt_limit (reset 10).
// A request is decoded in the cycle it is accepted; the sequencer state updates
// at that edge and its results (zero to three) land in a four-entry queue.
// If the queue is empty, the first result is offered the cycle after acceptance; a
// three-byte command burst drains one result per cycle while i_out_stall is low.
// Throughput: one request per cycle while the queue holds at most one result;
// the queue depth and its single read port set this, so each of an STX request's
// three results takes an output slot.
// o_in_stall rises when the queue cannot take a full burst; a stall on the
// output holds the head result and fills the queue until input stalls too.
// Reset (synchronous, active low) returns to idle, clears the queue and the
// counters and restores the register defaults.
`timescale 1ns / 1ps
`include "uart_boot_image_loader_defines.svh"

module uart_boot_image_loader
    import ubl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_send_valid,
    output logic [7:0]  o_send_byte,
    output logic        o_last_of_run,
    output logic        o_firmware_wanted,
    output logic        o_finished,
    output logic [1:0]  o_fail_cause,
    output logic        o_close_link,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_image_length;
    logic [7:0]  r_attempt_limit;
    logic        in_accept;
    t_burst      burst;
    t_result     head;
    logic [2:0]  q_count;
    logic [3:0]  phase;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_length  <= '0;
            r_attempt_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_LENGTH:  r_image_length  <= i_cfg_data;
                REG_ATTEMPT_LIMIT: r_attempt_limit <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // hold input while the queue lacks room for a full burst
    assign o_in_stall = (q_count > 3'd1);
    assign in_accept  = i_in_valid && !o_in_stall;

    ubl_fsm u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_kind          (i_kind),
        .i_data_byte     (i_data_byte),
        .i_image_length  (r_image_length),
        .i_attempt_limit (r_attempt_limit),
        .o_burst         (burst),
        .o_phase         (phase)
    );

    ubl_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_burst (burst),
        .i_pop   (!i_out_stall),
        .o_valid (o_out_valid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_send_valid      = head.send_valid;
    assign o_send_byte       = head.send_byte;
    assign o_last_of_run     = head.last_of_run;
    assign o_firmware_wanted = head.firmware_wanted;
    assign o_finished        = head.finished;
    assign o_fail_cause      = head.fail_cause;
    assign o_close_link      = head.close_link;

    `UBL_ASSERT_IMP(a_queue_bound, 1'b1, q_count <= 3'd4)
    `UBL_ASSERT_IMP(a_finish_last, o_out_valid && o_finished, o_last_of_run)
    `UBL_ASSERT_IMP(a_fw_only, o_out_valid && o_firmware_wanted,
                    !o_send_valid && !o_finished && o_last_of_run)
    `UBL_ASSERT_NXT(a_start_waits, in_accept && i_kind == K_START, phase == PH_W4_STX)

endmodule

// ----- hdl/ubl_fsm.sv -----
// Handshake sequencer: phase, attempt count, running XOR and stream count.
// Depends on ubl_pkg; produces one burst of results per accepted request.
`timescale 1ns / 1ps

module ubl_fsm
    import ubl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_image_length,
    input  logic [7:0]  i_attempt_limit,
    output t_burst      o_burst,
    output logic [3:0]  o_phase
);

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_attempts, n_attempts;
    logic [7:0]  r_xor, n_xor;
    logic [15:0] r_streamed, n_streamed;
    logic [7:0]  att_inc;
    t_burst      burst;

    function automatic t_result mk(logic sv, logic [7:0] sb, logic fw, logic fin,
                                   logic [1:0] cause, logic cl);
        t_result r;
        r.send_valid      = sv;
        r.send_byte       = sb;
        r.last_of_run     = 1'b0;
        r.firmware_wanted = fw;
        r.finished        = fin;
        r.fail_cause      = cause;
        r.close_link      = cl;
        return r;
    endfunction

    assign att_inc = (r_attempts == 8'hFF) ? r_attempts : r_attempts + 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_attempts = r_attempts;
        n_xor      = r_xor;
        n_streamed = r_streamed;
        burst      = '0;
        if (i_kind == K_START) begin
            n_attempts = '0;
            n_phase    = PH_W4_STX;
        end else begin
            case (r_phase)
                PH_W4_STX: begin
                    if (i_kind == K_RX && i_data_byte == B_STX) begin
                        burst.res[0] = mk(1'b1, B_SOH, 1'b0, 1'b0, C_SUCCESS, 1'b0);
                        burst.res[1] = mk(1'b1, i_image_length[7:0], 1'b0, 1'b0,
                                          C_SUCCESS, 1'b0);
                        burst.res[2] = mk(1'b1, i_image_length[15:8], 1'b0, 1'b0,
                                          C_SUCCESS, 1'b0);
                        burst.res[2].last_of_run = 1'b1;
                        burst.count = 2'd3;
                        n_phase = PH_W4_SENT;
                    end
                end
                PH_W4_SENT: begin
                    if (i_kind == K_TXDONE) n_phase = PH_W4_ACK;
                end
                PH_W4_ACK: begin
                    if (i_kind == K_RX) begin
                        if (i_data_byte == B_ACK) begin
                            burst.res[0] = mk(1'b0, 8'h00, 1'b1, 1'b0, C_SUCCESS, 1'b0);
                            burst.count  = 2'd1;
                            n_xor        = XOR_INIT;
                            n_streamed   = '0;
                            n_phase      = PH_STREAM;
                        end else if (i_data_byte == B_NACK) begin
                            burst.res[0] = mk(1'b0, 8'h00, 1'b0, 1'b1, C_REFUSED, 1'b1);
                            burst.count  = 2'd1;
                            n_phase      = PH_DONE;
                        end else begin
                            n_attempts = att_inc;
                            if (att_inc < i_attempt_limit) begin
                                n_phase = PH_W4_STX;
                            end else begin
                                burst.res[0] = mk(1'b0, 8'h00, 1'b0, 1'b1, C_EXHAUST, 1'b1);
                                burst.count  = 2'd1;
                                n_phase      = PH_DONE;
                            end
                        end
                    end
                end
                PH_STREAM: begin
                    if (i_kind == K_FW && r_streamed < i_image_length) begin
                        burst.res[0] = mk(1'b1, i_data_byte, 1'b0, 1'b0, C_SUCCESS, 1'b0);
                        burst.count  = 2'd1;
                        n_xor        = r_xor ^ i_data_byte;
                        n_streamed   = r_streamed + 16'd1;
                    end else if (i_kind == K_TXDONE && r_streamed == i_image_length) begin
                        n_phase = PH_W4_CRC;
                    end
                end
                PH_W4_CRC: begin
                    if (i_kind == K_RX) begin
                        burst.count = 2'd1;
                        if (i_data_byte != r_xor) begin
                            burst.res[0] = mk(1'b0, 8'h00, 1'b0, 1'b1, C_MISMATCH, 1'b0);
                            n_phase      = PH_DONE;
                        end else begin
                            burst.res[0] = mk(1'b1, B_ACK, 1'b0, 1'b0, C_SUCCESS, 1'b0);
                            n_phase      = PH_W4_FINAL;
                        end
                    end
                end
                PH_W4_FINAL: begin
                    if (i_kind == K_TXDONE) begin
                        burst.res[0] = mk(1'b0, 8'h00, 1'b0, 1'b1, C_SUCCESS, 1'b0);
                        burst.count  = 2'd1;
                        n_phase      = PH_DONE;
                    end
                end
                default: begin
                    // idle and done ignore everything but start
                end
            endcase
            // single-result bursts end on slot 0
            if (burst.count == 2'd1) burst.res[0].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_attempts <= '0;
            r_xor      <= XOR_INIT;
            r_streamed <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_attempts <= n_attempts;
            r_xor      <= n_xor;
            r_streamed <= n_streamed;
        end
    end

    assign o_burst = i_accept ? burst : '0;
    assign o_phase = r_phase;

endmodule

// ----- hdl/ubl_result_fifo.sv -----
// Four-entry result queue; takes up to three results a cycle, hands out one.
// Depends on ubl_pkg for t_result and t_burst.
`timescale 1ns / 1ps

module ubl_result_fifo
    import ubl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_burst     i_burst,
    input  logic       i_pop,
    output logic       o_valid,
    output t_result    o_head,
    output logic [2:0] o_count
);

    t_result    r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign pop     = i_pop && (r_count != 3'd0);
    assign n_count = r_count + {1'b0, i_burst.count} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (k < int'(i_burst.count)) r_mem[r_wr + 2'(k)] <= i_burst.res[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + i_burst.count;
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule
